[design/relay_bank_interval_timer_assert.svh]
// Assertion macros shared by the checker files of the relay bank timer.
`ifndef RELAY_BANK_INTERVAL_TIMER_ASSERT_SVH
`define RELAY_BANK_INTERVAL_TIMER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define RBIT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RBIT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/rbit_pkg.sv]
// Shared constants, codes and types of the relay bank interval timer.
package rbit_pkg;

    localparam int NUM_RELAYS      = 6;
    localparam int PERIOD_BITS     = 24;
    localparam int ID_BITS         = 3;
    localparam int OP_BITS         = 2;
    localparam int AUTO_BITS       = 6;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = (PERIOD_BITS > AUTO_BITS) ? PERIOD_BITS : AUTO_BITS;
    localparam int NUM_PERIOD_REGS = 6;
    localparam int IN_DATA_BITS    = ((ID_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS   = ((2 * NUM_RELAYS + 7) / 8) * 8;

    localparam logic [PERIOD_BITS-1:0]    MIN_PERIOD   = PERIOD_BITS'(1000);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AUTO_IDX = 3'd6;

    localparam logic [OP_BITS-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ENABLE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DISABLE = 2'd2;

    // Command to one relay lane for the word now being executed.
    typedef struct packed {
        logic step;
        logic tick;
        logic en;
        logic dis;
    } t_lane_cmd;

    // Configuration write as seen by one relay lane.
    typedef struct packed {
        logic                   period_we;
        logic [PERIOD_BITS-1:0] data;
    } t_lane_cfg;

endpackage

[design/rbit_relay_lane.sv]
// One relay lane: period register, latched period, millisecond counter, drive bits.
module rbit_relay_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbit_pkg::t_lane_cmd i_cmd,
    input  rbit_pkg::t_lane_cfg i_cfg,
    input  logic                i_auto,
    output logic                o_out_next,
    output logic                o_run_next
);
    import rbit_pkg::*;

    logic [PERIOD_BITS-1:0] r_period;
    logic [PERIOD_BITS-1:0] r_latched, n_latched;
    logic [PERIOD_BITS-1:0] r_elapsed, n_elapsed;
    logic                   r_out, n_out;
    logic                   r_run, n_run;
    logic [PERIOD_BITS-1:0] inc;

    assign inc = r_elapsed + PERIOD_BITS'(1);

    always_comb begin
        n_latched = r_latched;
        n_elapsed = r_elapsed;
        n_out     = r_out;
        n_run     = r_run;
        if (i_cmd.tick && r_run) begin
            if (inc >= r_latched) begin
                n_elapsed = '0;
                if (i_auto) begin
                    n_out = ~r_out;
                end else begin
                    n_out = 1'b0;
                    n_run = 1'b0;
                end
            end else begin
                n_elapsed = inc;
            end
        end else if (i_cmd.en && !r_run) begin
            n_out     = 1'b1;
            n_run     = 1'b1;
            n_elapsed = '0;
            n_latched = r_period;
        end else if (i_cmd.dis) begin
            n_out     = 1'b0;
            n_run     = 1'b0;
            n_elapsed = '0;
        end
    end

    assign o_out_next = n_out;
    assign o_run_next = n_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= MIN_PERIOD;
            r_latched <= MIN_PERIOD;
            r_elapsed <= '0;
            r_out     <= 1'b0;
            r_run     <= 1'b0;
        end else begin
            // Writes below the minimum period are dropped.
            if (i_cfg.period_we && (i_cfg.data >= MIN_PERIOD)) begin
                r_period <= i_cfg.data;
            end
            if (i_cmd.step) begin
                r_latched <= n_latched;
                r_elapsed <= n_elapsed;
                r_out     <= n_out;
                r_run     <= n_run;
            end
        end
    end

endmodule

[design/relay_bank_interval_timer.sv]
// Top level of the relay bank interval timer: input register, relay lanes, result register.
//
// Usage: words arrive on the slave stream. tuser carries the operation (tick, enable,
// disable) and tdata carries the relay id. Every accepted word returns exactly one word
// on the master stream holding the relay drive mask and the running mask.
// Flow: an accepted word is held in the input register and executed once the result
// register can load; its result is then valid in the result register.
// Throughput: one word per cycle unless stalled. The relay lanes and the result register
// update in the same cycle: six counters with a compare each are the only logic in the path.
// Stalls: while the receiver holds tready low the result stays put and the input
// register can still take one more word; then tready on the slave side drops.
// Reset: synchronous, active low. All relays go off and idle, periods return to 1000 ms,
// the auto mask clears, and both stream stages empty.
// Configuration: register index 0 to 5 sets a relay period (values under 1000 are
// ignored), index 6 sets the auto mask. A running timer keeps the period it latched
// at enable. Writes are expected only while the block is idle.
module relay_bank_interval_timer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Slave stream.
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [rbit_pkg::IN_DATA_BITS-1:0]     i_s_tdata,  // [2:0] relay_id
    input  logic [rbit_pkg::OP_BITS-1:0]          i_s_tuser,  // [1:0] op
    // Master stream.
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [rbit_pkg::OUT_DATA_BITS-1:0]    o_m_tdata,  // relay_outputs, relays_running
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [rbit_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [rbit_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);
    import rbit_pkg::*;

    logic                   r_in_valid;
    logic [OP_BITS-1:0]     r_in_op;
    logic [ID_BITS-1:0]     r_in_id;
    logic                   r_out_valid;
    logic [NUM_RELAYS-1:0]  r_out_bits;
    logic [NUM_RELAYS-1:0]  r_run_bits;
    logic [NUM_RELAYS-1:0]  r_auto;
    logic [NUM_RELAYS-1:0]  out_next;
    logic [NUM_RELAYS-1:0]  run_next;
    logic                   advance;
    logic                   step;
    logic [31:0]            auto_ext;

    // The result register can load when it is empty or being drained this cycle.
    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign auto_ext   = 32'(i_cfg_wdata[AUTO_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_auto      <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we && (i_cfg_index == CFG_AUTO_IDX)) begin
                r_auto <= auto_ext[NUM_RELAYS-1:0];
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op <= i_s_tuser;
            r_in_id <= i_s_tdata[ID_BITS-1:0];
        end
        if (step) begin
            r_out_bits <= out_next;
            r_run_bits <= run_next;
        end
    end

    // One lane per relay. An enable or disable whose id matches no lane leaves the bank unchanged.
    for (genvar gi = 0; gi < NUM_RELAYS; gi++) begin : g_lane
        t_lane_cmd cmd;
        t_lane_cfg cfg;
        logic      sel;

        assign sel            = (32'(r_in_id) == gi);
        assign cmd.step       = step;
        assign cmd.tick       = (r_in_op == OP_TICK);
        assign cmd.en         = (r_in_op == OP_ENABLE) && sel;
        assign cmd.dis        = (r_in_op == OP_DISABLE) && sel;
        assign cfg.period_we  = i_cfg_we && (32'(i_cfg_index) == gi) &&
                                (gi < NUM_PERIOD_REGS);
        assign cfg.data       = i_cfg_wdata[PERIOD_BITS-1:0];

        rbit_relay_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_cfg      (cfg),
            .i_auto     (r_auto[gi]),
            .o_out_next (out_next[gi]),
            .o_run_next (run_next[gi])
        );
    end

    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[2*NUM_RELAYS-1:0] = {r_run_bits, r_out_bits};
    end

endmodule

[design/rbit_checker.sv]
// Port-level checker of the relay bank interval timer and its bind statement.
`include "relay_bank_interval_timer_assert.svh"

module rbit_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_s_tready,
    input logic                                  o_m_tvalid,
    input logic                                  i_m_tready,
    input logic [rbit_pkg::OUT_DATA_BITS-1:0]    o_m_tdata
);
    import rbit_pkg::*;

    logic [NUM_RELAYS-1:0] drive_mask;
    logic [NUM_RELAYS-1:0] run_mask;

    assign drive_mask = o_m_tdata[NUM_RELAYS-1:0];
    assign run_mask   = o_m_tdata[2*NUM_RELAYS-1:NUM_RELAYS];

    `RBIT_ASSERT(a_hold_on_stall, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result word changed while stalled")
    `RBIT_ASSERT(a_drive_needs_run, i_clk, i_rst_n, o_m_tvalid |-> ((drive_mask & ~run_mask) == '0), "relay driven while its timer is stopped")
    `RBIT_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready, "input stalled with an empty result stage")
    `RBIT_ASSERT(a_pad_zero, i_clk, i_rst_n, o_m_tvalid |-> ((o_m_tdata >> (2 * NUM_RELAYS)) == '0), "padding bits of result word not zero")
    `RBIT_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")

endmodule

bind relay_bank_interval_timer rbit_checker u_rbit_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[tb/tb.sv]
// Self-checking testbench of the relay bank interval timer: directed table, then random words.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbit_pkg::*;

    // The package names only the three live operations; the fourth code must be a no-op.
    localparam logic [OP_BITS-1:0]        OP_UNUSED    = 2'd3;
    // Index 7 addresses no register at all.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NONE_IDX = 3'd7;
    localparam logic [PERIOD_BITS-1:0]    PERIOD_MAX   = '1;
    localparam int MAX_GAP      = 19;
    // Safety margin waited after the last owed word has come back.
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_RUN     = 1150;
    localparam int NOISE_RUN    = 100;

    // One result word split into its two fields.
    typedef struct packed {
        logic [NUM_RELAYS-1:0] drive;
        logic [NUM_RELAYS-1:0] running;
    } t_masks;

    // One row of the directed table. When typed is set, drive and running hold the
    // expected masks as read off the behavior by hand; otherwise the predictor decides.
    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [ID_BITS-1:0]    id;
        logic                  typed;
        logic [NUM_RELAYS-1:0] drive;
        logic [NUM_RELAYS-1:0] running;
    } t_stim_row;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [IN_DATA_BITS-1:0]    s_tdata     = '0;
    logic [OP_BITS-1:0]         s_tuser     = OP_TICK;
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [OUT_DATA_BITS-1:0]   m_tdata;
    logic                       cfg_we      = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata   = '0;

    relay_bank_interval_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),    // [2:0] relay_id
        .i_s_tuser   (s_tuser),    // [1:0] op
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),    // [5:0] relay_outputs, [11:6] relays_running
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predictor state: our own copy of the registers and of every relay lane.
    logic [PERIOD_BITS-1:0] period_q  [NUM_RELAYS];
    logic [PERIOD_BITS-1:0] latched_q [NUM_RELAYS];
    logic [PERIOD_BITS-1:0] elapsed_q [NUM_RELAYS];
    logic [NUM_RELAYS-1:0]  auto_q;
    logic [NUM_RELAYS-1:0]  drive_q;
    logic [NUM_RELAYS-1:0]  run_q;

    // Masks that the block still owes us, oldest first.
    t_masks pending_masks [$];
    int     error_count = 0;

    // When set, that side runs flat out with no idle cycles.
    logic tx_rush = 1'b0;
    logic rx_rush = 1'b0;

    // Directed table. The opening rows run straight out of reset with every period at
    // 1000 ms and the auto mask clear, so their masks can be typed in. They cover ticks
    // with both extremes of relay_id, the unused operation, a disable of an idle relay,
    // enables and disables of ids 6 and 7 that must be dropped, and a second enable of a
    // relay that is already running, which must be ignored.
    t_stim_row directed_rows [24] = '{
        {OP_TICK,    3'd0, 1'b1, 6'h00, 6'h00},
        {OP_TICK,    3'd7, 1'b1, 6'h00, 6'h00},
        {OP_UNUSED,  3'd5, 1'b1, 6'h00, 6'h00},
        {OP_DISABLE, 3'd0, 1'b1, 6'h00, 6'h00},
        {OP_ENABLE,  3'd0, 1'b1, 6'h01, 6'h01},
        {OP_ENABLE,  3'd5, 1'b1, 6'h21, 6'h21},
        {OP_ENABLE,  3'd6, 1'b1, 6'h21, 6'h21},
        {OP_ENABLE,  3'd7, 1'b1, 6'h21, 6'h21},
        {OP_ENABLE,  3'd0, 1'b1, 6'h21, 6'h21},
        {OP_TICK,    3'd2, 1'b1, 6'h21, 6'h21},
        {OP_DISABLE, 3'd7, 1'b1, 6'h21, 6'h21},
        {OP_DISABLE, 3'd6, 1'b1, 6'h21, 6'h21},
        {OP_DISABLE, 3'd5, 1'b1, 6'h01, 6'h01},
        {OP_ENABLE,  3'd3, 1'b1, 6'h09, 6'h09},
        {OP_ENABLE,  3'd2, 1'b1, 6'h0D, 6'h0D},
        {OP_ENABLE,  3'd4, 1'b1, 6'h1D, 6'h1D},
        {OP_ENABLE,  3'd1, 1'b1, 6'h1F, 6'h1F},
        {OP_ENABLE,  3'd5, 1'b1, 6'h3F, 6'h3F},
        {OP_UNUSED,  3'd7, 1'b1, 6'h3F, 6'h3F},
        {OP_TICK,    3'd5, 1'b0, 6'h00, 6'h00},
        {OP_DISABLE, 3'd0, 1'b1, 6'h3E, 6'h3E},
        {OP_UNUSED,  3'd0, 1'b0, 6'h00, 6'h00},
        {OP_ENABLE,  3'd0, 1'b0, 6'h00, 6'h00},
        {OP_TICK,    3'd1, 1'b0, 6'h00, 6'h00}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advances the predictor by one accepted word and returns the masks it leaves.
    function automatic t_masks predict_masks(input logic [OP_BITS-1:0] op,
                                             input logic [ID_BITS-1:0] id);
        t_masks m;
        if (op == OP_TICK) begin
            // Every running timer counts; at its latched period an auto relay flips and
            // starts over, a plain relay drops out.
            for (int r = 0; r < NUM_RELAYS; r++) begin
                if (run_q[r]) begin
                    elapsed_q[r] = elapsed_q[r] + 1'b1;
                    if (elapsed_q[r] >= latched_q[r]) begin
                        elapsed_q[r] = '0;
                        if (auto_q[r]) begin
                            drive_q[r] = ~drive_q[r];
                        end else begin
                            drive_q[r] = 1'b0;
                            run_q[r]   = 1'b0;
                        end
                    end
                end
            end
        end else if (op == OP_ENABLE) begin
            // The period is captured here; a later register write does not touch it.
            if (int'(id) < NUM_RELAYS && !run_q[id]) begin
                drive_q[id]   = 1'b1;
                run_q[id]     = 1'b1;
                elapsed_q[id] = '0;
                latched_q[id] = period_q[id];
            end
        end else if (op == OP_DISABLE) begin
            if (int'(id) < NUM_RELAYS) begin
                drive_q[id]   = 1'b0;
                run_q[id]     = 1'b0;
                elapsed_q[id] = '0;
            end
        end
        m.drive   = drive_q;
        m.running = run_q;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("mismatch in %s at %0t: expected %h, got %h", what, $time, want, got);
        error_count++;
    endtask

    // Writes one register. The enable is dropped on a cycle of its own so that two
    // writes in a row never assign it twice in the same time step.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0]  val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx < NUM_PERIOD_REGS) begin
            // Periods below the minimum are refused and the old value stays.
            if (val[PERIOD_BITS-1:0] >= MIN_PERIOD)
                period_q[idx] = val[PERIOD_BITS-1:0];
        end else if (idx == CFG_AUTO_IDX) begin
            auto_q = val[NUM_RELAYS-1:0];
        end
    endtask

    // Offers one word after a random gap and waits for the handshake. Ready is sampled
    // on the falling edge, where every signal is settled, and the word counts as taken
    // at the following rising edge. With no gap, valid simply stays high.
    task automatic send_word(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                             input logic typed, input t_masks typed_masks);
        int     gap;
        logic   ready_seen;
        t_masks predicted;
        if ($urandom_range(0, 39) == 0)
            tx_rush = ~tx_rush;
        gap = tx_rush ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_BITS'(id);
        s_tuser  <= op;
        do begin
            @(negedge i_clk);
            ready_seen = s_tready;
            @(posedge i_clk);
        end while (ready_seen !== 1'b1);
        // The predictor always advances, even where the table supplies the answer.
        predicted = predict_masks(op, id);
        pending_masks.push_back(typed ? typed_masks : predicted);
    endtask

    // Stops sending and waits until every owed word has come back, plus a margin.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: stalls a random number of cycles per word, then takes one word and
    // checks both fields against the oldest expectation.
    initial begin
        int                     stall;
        logic                   seen_valid;
        logic [OUT_DATA_BITS-1:0] seen_data;
        t_masks                 got;
        t_masks                 want;
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_rush = ~rx_rush;
            stall = rx_rush ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                seen_valid = m_tvalid;
                seen_data  = m_tdata;
                @(posedge i_clk);
            end while (seen_valid !== 1'b1);
            got.drive   = seen_data[NUM_RELAYS-1:0];
            got.running = seen_data[2*NUM_RELAYS-1:NUM_RELAYS];
            if (pending_masks.size() == 0) begin
                report_mismatch("unexpected word", 16'h0, 16'(seen_data));
            end else begin
                want = pending_masks.pop_front();
                if (got.drive !== want.drive)
                    report_mismatch("relay_outputs", 16'(want.drive), 16'(got.drive));
                if (got.running !== want.running)
                    report_mismatch("relays_running", 16'(want.running), 16'(got.running));
            end
        end
    end

    // Stimulus: reset, the directed table, then two random phases under different
    // register settings.
    initial begin
        int                   pick;
        logic [OP_BITS-1:0]   op;
        logic [ID_BITS-1:0]   id;
        t_stim_row            row;
        for (int r = 0; r < NUM_RELAYS; r++) begin
            period_q[r]  = MIN_PERIOD;
            latched_q[r] = MIN_PERIOD;
            elapsed_q[r] = '0;
        end
        auto_q  = '0;
        drive_q = '0;
        run_q   = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_word(row.op, row.id, row.typed, {row.drive, row.running});
        end
        wait_drained();

        // Long phase: periods at or just above the minimum and a mixed auto mask, and
        // almost only ticks, so that timers run all the way to expiry. Relays left running
        // by the table keep the period they latched at enable.
        for (int r = 0; r < NUM_RELAYS; r++)
            write_reg(CFG_INDEX_BITS'(r), CFG_DATA_BITS'(MIN_PERIOD + PERIOD_BITS'(r * 7)));
        write_reg(CFG_AUTO_IDX, CFG_DATA_BITS'($urandom_range(1, 62)));
        for (int n = 0; n < LONG_RUN; n++) begin
            if (n == LONG_RUN / 2) begin
                // Let the pipe empty completely, then give one relay the longest period
                // while it may still be counting on its latched one.
                wait_drained();
                write_reg(CFG_INDEX_BITS'($urandom_range(0, NUM_RELAYS - 1)), PERIOD_MAX);
            end
            pick = $urandom_range(0, 199);
            if (pick < 190)
                op = OP_TICK;
            else if (pick < 196)
                op = OP_ENABLE;
            else if (pick < 198)
                op = OP_DISABLE;
            else
                op = OP_UNUSED;
            id = ID_BITS'($urandom_range(0, 7));
            send_word(op, id, 1'b0, '0);
        end
        wait_drained();

        // Noise phase: extreme and random periods, refused short writes, a write to the
        // missing register, every relay in auto mode, and operations drawn uniformly.
        write_reg(CFG_INDEX_BITS'(0), PERIOD_MAX);
        for (int r = 1; r < NUM_RELAYS; r++)
            write_reg(CFG_INDEX_BITS'(r), CFG_DATA_BITS'($urandom_range(1000, 24'hFFFFFF)));
        write_reg(CFG_INDEX_BITS'(2), CFG_DATA_BITS'(999));
        write_reg(CFG_INDEX_BITS'(3), '0);
        write_reg(CFG_NONE_IDX, '1);
        write_reg(CFG_AUTO_IDX, CFG_DATA_BITS'(6'h3F));
        for (int n = 0; n < NOISE_RUN; n++) begin
            op = OP_BITS'($urandom_range(0, 3));
            id = ID_BITS'($urandom_range(0, 7));
            send_word(op, id, 1'b0, '0);
        end
        wait_drained();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog, many times the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
